/* src/xrc_pkg.sv */
// Package for the XOR-ramp cipher with checksum unit.
// Transaction payload types, command, kind and register codes.
// No dependencies; used by every file in src.
`timescale 1ns / 1ps
`default_nettype none

package xrc_pkg;

	localparam int MAX_RESULTS = 5;
	localparam logic [7:0] BYTE_MASK = 8'hFF;

	// input command codes
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// direction register codes
	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	// result kind codes
	localparam logic [1:0] KIND_HEADER   = 2'd0;
	localparam logic [1:0] KIND_CHECKSUM = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD  = 2'd2;
	localparam logic [1:0] KIND_VERDICT  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_BYTES     = 2'd0;
	localparam logic [1:0] REG_CHECKSUM_MASK = 2'd1;
	localparam logic [1:0] REG_DIRECTION     = 2'd2;

	// header phase at which the eight header bytes have been absorbed
	localparam logic [3:0] PHASE_DONE = 4'd8;

	typedef struct packed {
		logic        command;
		logic [23:0] length;
		logic [7:0]  data_byte;
		logic        last;
	} xrc_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       check_ok;
		logic       end_of_run;
	} xrc_result_t;

endpackage

`default_nettype wire

/* src/xor_ramp_cipher_with_checksum_unit.sv */
// XOR-ramp byte cipher with running checksum: top level.
// Depends on xrc_pkg (payload structs, codes).
//
// Usage:
//  - item channel (item_valid/item_ready/item): one transaction per byte or
//    per begin command. Begin in encrypt direction yields four header bytes;
//    a data byte yields one payload byte, plus four checksum bytes (encrypt)
//    or a verdict (decrypt) when it carries last. Decrypt header bytes yield
//    nothing unless last; a last before all eight are in fails the verdict.
//  - result channel (result_valid/result_ready/result): one result per
//    transaction, end_of_run set on the final result an item causes.
//  - cfg port: single-cycle writes of key, checksum mask, direction; they are
//    to be written only while the unit is idle; the unit does not enforce this.
// Latency: an item accepted at edge k shows its first result after edge k.
// Throughput: one result per cycle while result_ready is high. The result buffer
//    holds up to five results; a new item is taken when it is empty or its final
//    entry is being taken in the same cycle, so single-result items stream at one
//    per cycle while result_ready is high; an item yields 0..5 results.
// The per-item logic is one 8 x LEN_BITS multiply plus a 32-bit add/compare.
// Reset: clears config, message state and the result count, not the buffer entries.
// Stall: while result_ready is low the buffer holds and item_ready stays low
//    as long as any result is pending.
`timescale 1ns / 1ps
`default_nettype none

module xor_ramp_cipher_with_checksum_unit
	import xrc_pkg::*;
#(
	parameter int LEN_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// item channel
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire xrc_item_t   item,
	// result channel
	output logic             result_valid,
	input  wire logic        result_ready,
	output xrc_result_t      result
);

	localparam int PROD_W = LEN_BITS + 8;

	// configuration registers
	logic [31:0] key_bytes_q;
	logic [31:0] checksum_mask_q;
	logic        direction_q;

	// message state
	logic [7:0]          hkey_q [4];
	logic [LEN_BITS-1:0] byte_index_q;
	logic [31:0]         running_sum_q;
	logic [31:0]         stored_sum_q;
	logic [31:0]         decoded_length_q;
	logic [3:0]          header_phase_q;

	// result buffer, entry 0 is the one on offer
	xrc_result_t res_q [MAX_RESULTS];
	logic [2:0]  cnt_q;

	// next-state values
	logic [7:0]          hkey_d [4];
	logic [LEN_BITS-1:0] byte_index_d;
	logic [31:0]         running_sum_d;
	logic [31:0]         stored_sum_d;
	logic [31:0]         decoded_length_d;
	logic [3:0]          header_phase_d;
	xrc_result_t         res_d [MAX_RESULTS];
	logic [2:0]          n_d;

	logic                item_fire;
	logic                result_fire;
	logic [LEN_BITS-1:0] j;
	logic [LEN_BITS-1:0] len_m;
	logic [31:0]         len32;
	logic [7:0]          kstream;
	logic [7:0]          cipher;
	logic [7:0]          mul_byte;
	logic [PROD_W-1:0]   prod;
	logic [31:0]         sum_upd;
	logic [7:0]          kb_hdr;
	logic [31:0]         cs;

	assign result_fire = result_valid && result_ready;
	assign item_ready  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && result_ready);
	assign item_fire   = item_valid && item_ready;

	assign result_valid = (cnt_q != 3'd0);
	assign result       = res_q[0];

	assign j     = byte_index_q;
	assign len_m = LEN_BITS'(32'(item.length));
	assign len32 = 32'(len_m);

	// keystream byte: xor of the four header bytes each offset by the index
	assign kstream = (hkey_q[0] + j[7:0]) ^ (hkey_q[1] + j[7:0]) ^
	                 (hkey_q[2] + j[7:0]) ^ (hkey_q[3] + j[7:0]);
	assign cipher  = item.data_byte ^ kstream;

	// checksum term c*j + j; decrypt sums the received cipher byte
	assign mul_byte = (direction_q == DIR_DECRYPT) ? item.data_byte : cipher;
	assign prod     = PROD_W'(mul_byte) * PROD_W'(j);
	assign sum_upd  = running_sum_q + 32'(prod) + 32'(j);
	assign cs       = sum_upd ^ checksum_mask_q;

	// key byte matching the header byte position during decrypt
	always_comb begin
		unique case (header_phase_q[1:0])
			2'd0:    kb_hdr = key_bytes_q[31:24];
			2'd1:    kb_hdr = key_bytes_q[23:16];
			2'd2:    kb_hdr = key_bytes_q[15:8];
			default: kb_hdr = key_bytes_q[7:0];
		endcase
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hkey_d[i] = hkey_q[i];
		end
		byte_index_d     = byte_index_q;
		running_sum_d    = running_sum_q;
		stored_sum_d     = stored_sum_q;
		decoded_length_d = decoded_length_q;
		header_phase_d   = header_phase_q;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res_d[i] = '0;
		end
		n_d = 3'd0;

		if (item.command == CMD_BEGIN) begin
			for (int i = 0; i < 4; i++) begin
				hkey_d[i] = '0;
			end
			byte_index_d     = '0;
			running_sum_d    = '0;
			stored_sum_d     = '0;
			header_phase_d   = '0;
			decoded_length_d = '0;
			if (direction_q == DIR_ENCRYPT) begin
				decoded_length_d = len32;
				for (int i = 0; i < 4; i++) begin
					hkey_d[i]         = len32[31-8*i -: 8] ^ key_bytes_q[31-8*i -: 8];
					res_d[i].out_byte = hkey_d[i];
					res_d[i].kind     = KIND_HEADER;
				end
				n_d = 3'd4;
			end
		end else if (direction_q == DIR_ENCRYPT) begin
			running_sum_d     = sum_upd;
			byte_index_d      = j + 1'b1;
			res_d[0].out_byte = cipher;
			res_d[0].kind     = KIND_PAYLOAD;
			n_d               = 3'd1;
			if (item.last) begin
				for (int i = 0; i < 4; i++) begin
					res_d[i+1].out_byte = cs[8*i +: 8];
					res_d[i+1].kind     = KIND_CHECKSUM;
				end
				n_d            = 3'd5;
				byte_index_d   = '0;
				running_sum_d  = '0;
				header_phase_d = '0;
			end
		end else begin
			if (header_phase_q < 4'd4) begin
				hkey_d[header_phase_q[1:0]] = item.data_byte;
				decoded_length_d = {decoded_length_q[23:0], item.data_byte ^ kb_hdr};
				header_phase_d   = header_phase_q + 4'd1;
			end else if (header_phase_q < PHASE_DONE) begin
				stored_sum_d[8*header_phase_q[1:0] +: 8] = item.data_byte;
				header_phase_d = header_phase_q + 4'd1;
			end else begin
				running_sum_d = sum_upd;
				byte_index_d  = j + 1'b1;
				// decode only below a non-negative header length
				if (!decoded_length_q[31] && (32'(j) < decoded_length_q)) begin
					res_d[0].out_byte = cipher;
				end else begin
					res_d[0].out_byte = item.data_byte;
				end
				res_d[0].kind = KIND_PAYLOAD;
				n_d           = 3'd1;
			end
			if (item.last) begin
				res_d[n_d[0]].kind     = KIND_VERDICT;
				res_d[n_d[0]].check_ok = header_phase_d[3] &&
				                         ((running_sum_d ^ checksum_mask_q) == stored_sum_d);
				n_d            = n_d + 3'd1;
				byte_index_d   = '0;
				running_sum_d  = '0;
				header_phase_d = '0;
			end
		end

		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (3'(i + 1) == n_d) begin
				res_d[i].end_of_run = 1'b1;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q     <= '0;
			checksum_mask_q <= '0;
			direction_q     <= DIR_ENCRYPT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KEY_BYTES:     key_bytes_q     <= cfg_data;
				REG_CHECKSUM_MASK: checksum_mask_q <= cfg_data;
				REG_DIRECTION:     direction_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				hkey_q[i] <= '0;
			end
			byte_index_q     <= '0;
			running_sum_q    <= '0;
			stored_sum_q     <= '0;
			decoded_length_q <= '0;
			header_phase_q   <= '0;
		end else if (item_fire) begin
			for (int i = 0; i < 4; i++) begin
				hkey_q[i] <= hkey_d[i];
			end
			byte_index_q     <= byte_index_d;
			running_sum_q    <= running_sum_d;
			stored_sum_q     <= stored_sum_d;
			decoded_length_q <= decoded_length_d;
			header_phase_q   <= header_phase_d;
		end
	end

	// result buffer: load on accept, else shift down as results leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (item_fire) begin
			cnt_q <= n_d;
		end else if (result_fire) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				res_q[i] <= res_d[i];
			end
		end else if (result_fire) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

/* src/xrc_checker.sv */
// Port-level checks for the XOR-ramp cipher unit, bound to the top level.
// Depends on xrc_pkg and xor_ramp_cipher_with_checksum_unit.
`timescale 1ns / 1ps
`default_nettype none

module xrc_checker
	import xrc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_ready,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire xrc_result_t result
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a verdict closes its run and carries no byte
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_VERDICT) |->
			result.end_of_run && (result.out_byte == 8'd0))
		else $error("verdict not final or nonzero byte");

	// check_ok only on a verdict
	a_ok_only_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind != KIND_VERDICT) |-> !result.check_ok)
		else $error("check_ok outside verdict");

	// while a result is pending that is not the final one, no new item is taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.end_of_run |-> !item_ready)
		else $error("item taken before run drained");

endmodule

bind xor_ramp_cipher_with_checksum_unit xrc_checker u_xrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

/* tb/tb_xor_ramp_cipher_with_checksum_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for xor_ramp_cipher_with_checksum_unit: a directed table, then
// random encrypt and decrypt messages, scored by an in-bench cipher predictor or typed rows.
// Depends on xrc_pkg and the unit RTL in src.

module tb_xor_ramp_cipher_with_checksum_unit;
	import xrc_pkg::*;

	localparam int QUIET_LIMIT   = 4000;	// cycles with no transaction at all
	localparam int SETTLE_CYCLES = 8;	// covers the unit latency before a cfg write
	localparam int MAX_SHOWN     = 10;
	localparam int PHASE_ITEMS   = 18;
	localparam int NUM_PHASES    = 6;

	// directed table: a row is either a register write or an input transaction
	typedef enum logic {ROW_CFG, ROW_ITEM} row_op_e;
	// how a row's expectation is formed: from the predictor, or typed in the table
	typedef enum logic [1:0] {EXP_PREDICT, EXP_HEADER, EXP_VERDICT} exp_form_e;

	// word: register value for ROW_CFG; typed header bytes h0..h3 or the verdict
	// flag in bit 0 for ROW_ITEM
	typedef struct packed {
		row_op_e     op;
		logic [1:0]  reg_index;
		logic [31:0] word;
		exp_form_e   form;
		xrc_item_t   it;
	} stim_row_t;

	// block ports; every input starts at a known value
	logic        clk;
	logic        arst_n       = 1'b0;
	logic        cfg_wr_en    = 1'b0;
	logic [1:0]  cfg_index    = '0;
	logic [31:0] cfg_data     = '0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	xrc_item_t   item         = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	xrc_result_t result;

	// cipher predictor: register copies and message state
	logic [31:0] key_reg    = '0;
	logic [31:0] mask_reg   = '0;
	logic        dir_reg    = DIR_ENCRYPT;
	logic [7:0]  hdr_key [4] = '{default: 8'h00};
	logic [23:0] byte_pos   = '0;
	logic [31:0] run_sum    = '0;
	logic [31:0] stored_sum = '0;
	logic [31:0] msg_length = '0;
	logic [3:0]  hdr_phase  = '0;

	xrc_result_t expected_results [$];
	stim_row_t   directed_rows [$];

	int src_idle_pct = 31;
	int dst_idle_pct = 52;
	int items_sent   = 0;
	int results_seen = 0;
	int verdicts_ok  = 0;
	int verdicts_bad = 0;
	int errors       = 0;
	int quiet_cycles = 0;

	xor_ramp_cipher_with_checksum_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// keystream byte for payload index j: XOR of the four header bytes each
	// ramped by j, modulo 256
	function automatic logic [7:0] ramp_key(input logic [23:0] j);
		logic [7:0] k;
		k = 8'h00;
		for (int i = 0; i < 4; i++)
			k ^= hdr_key[i] + j[7:0];
		return k;
	endfunction

	// end of message keeps header bytes, stored sum and length
	task automatic close_message();
		byte_pos  = '0;
		run_sum   = '0;
		hdr_phase = '0;
	endtask

	task automatic cipher_step(input xrc_item_t it, output int n,
			output xrc_result_t [MAX_RESULTS-1:0] outs);
		logic [23:0] j;
		logic [7:0]  c;
		logic [7:0]  kb;
		logic [31:0] cs;
		logic        complete;
		logic        ok;
		outs     = '0;
		n        = 0;
		j        = byte_pos;
		complete = 1'b0;
		if (it.command == CMD_BEGIN) begin
			hdr_key    = '{default: 8'h00};
			byte_pos   = '0;
			run_sum    = '0;
			stored_sum = '0;
			hdr_phase  = '0;
			msg_length = '0;
			// begin in decrypt direction only clears state
			if (dir_reg == DIR_ENCRYPT) begin
				msg_length = {8'h00, it.length};
				for (int i = 0; i < 4; i++) begin
					hdr_key[i] = msg_length[31 - 8*i -: 8] ^ key_reg[31 - 8*i -: 8];
					outs[n] = xrc_result_t'({hdr_key[i], KIND_HEADER, 1'b0, 1'b0});
					n++;
				end
			end
		end else if (dir_reg == DIR_ENCRYPT) begin
			// every data byte is enciphered, whatever length was given
			c = it.data_byte ^ ramp_key(j);
			run_sum = run_sum + 32'(c) * 32'(j) + 32'(j);
			outs[n] = xrc_result_t'({c, KIND_PAYLOAD, 1'b0, 1'b0});
			n++;
			byte_pos = j + 24'd1;
			if (it.last) begin
				cs = run_sum ^ mask_reg;
				for (int i = 0; i < 4; i++) begin
					outs[n] = xrc_result_t'({cs[8*i +: 8], KIND_CHECKSUM, 1'b0, 1'b0});
					n++;
				end
				close_message();
			end
		end else begin
			if (hdr_phase < 4) begin
				kb = key_reg[31 - 8*hdr_phase -: 8];
				hdr_key[hdr_phase[1:0]] = it.data_byte;
				msg_length = {msg_length[23:0], it.data_byte ^ kb};
				hdr_phase++;
			end else if (hdr_phase < PHASE_DONE) begin
				stored_sum[8*(hdr_phase - 4) +: 8] = it.data_byte;
				hdr_phase++;
			end else begin
				// decode only below the header length; negative length decodes none
				c = it.data_byte;
				run_sum = run_sum + 32'(it.data_byte) * 32'(j) + 32'(j);
				if (!msg_length[31] && 32'(j) < msg_length)
					c = it.data_byte ^ ramp_key(j);
				outs[n] = xrc_result_t'({c, KIND_PAYLOAD, 1'b0, 1'b0});
				n++;
				byte_pos = j + 24'd1;
				complete = 1'b1;
			end
			if (it.last) begin
				// last while the header is incomplete always fails
				ok = (complete || hdr_phase >= PHASE_DONE) &&
					((run_sum ^ mask_reg) == stored_sum);
				outs[n] = xrc_result_t'({8'h00, KIND_VERDICT, ok, 1'b0});
				n++;
				close_message();
			end
		end
		if (n > 0)
			outs[n-1].end_of_run = 1'b1;
	endtask

	// ---------------------------------------------------------------- driving

	function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
		stim_row_t r;
		r = '0;
		r.op        = ROW_CFG;
		r.reg_index = idx;
		r.word      = val;
		return r;
	endfunction

	function automatic stim_row_t item_row(input logic cmd, input logic [23:0] len,
			input logic [7:0] b, input logic last, input exp_form_e form,
			input logic [31:0] word);
		stim_row_t r;
		r = '0;
		r.op   = ROW_ITEM;
		r.form = form;
		r.word = word;
		r.it   = xrc_item_t'({cmd, len, b, last});
		return r;
	endfunction

	// register write lands at the next edge; caller drops cfg_wr_en after a batch
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
		REG_KEY_BYTES: begin
			key_reg = val;
		end
		REG_CHECKSUM_MASK: begin
			mask_reg = val;
		end
		REG_DIRECTION: begin
			dir_reg = val[0];
		end
		default: begin
		end
		endcase
	endtask

	// hold the sender until all results are in, then let the unit settle
	// (decrypt header bytes give no result but may still be in flight)
	task automatic drain();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one input transaction; valid stays high afterward so the next one can
	// follow back to back
	task automatic send_item(input xrc_item_t it, input exp_form_e form,
			input logic [31:0] word);
		xrc_result_t [MAX_RESULTS-1:0] outs;
		int n;
		if ($urandom_range(99) < src_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		cipher_step(it, n, outs);
		case (form)
		EXP_HEADER: begin
			for (int k = 0; k < 4; k++)
				expected_results.push_back(xrc_result_t'({word[31 - 8*k -: 8],
					KIND_HEADER, 1'b0, 1'(k == 3)}));
		end
		EXP_VERDICT: begin
			expected_results.push_back(xrc_result_t'({8'h00, KIND_VERDICT, word[0], 1'b1}));
		end
		default: begin
			for (int k = 0; k < n; k++)
				expected_results.push_back(outs[k]);
		end
		endcase
		items_sent++;
	endtask

	// encrypt message: mostly begin + payload + last; some continue on the old
	// header, a few are noise with no last
	task automatic send_encrypt_message();
		int choice;
		int count;
		xrc_item_t it;
		choice = $urandom_range(99);
		count  = $urandom_range(1, 8);
		if (choice < 80) begin
			it = xrc_item_t'({CMD_BEGIN,
				($urandom_range(1) ? 24'($urandom) : 24'(count)),
				8'($urandom), 1'($urandom)});
			send_item(it, EXP_PREDICT, '0);
		end
		for (int k = 0; k < count; k++) begin
			it = xrc_item_t'({CMD_DATA, 24'($urandom), 8'($urandom),
				1'(k == count - 1 && choice < 95)});
			send_item(it, EXP_PREDICT, '0);
		end
	endtask

	// decrypt message: optional begin, header, stored checksum, cipher bytes.
	// The stored checksum is built to match unless deliberately corrupted; a
	// quarter of headers are random (negative lengths among them) and a tenth
	// of messages are cut short, with or without last.
	task automatic send_decrypt_message();
		xrc_item_t   msg [$];
		logic [7:0]  body [$];
		logic [31:0] hdr;
		logic [31:0] sum;
		xrc_item_t   it;
		int plen;
		int count;
		int cut;
		logic mark_last;
		plen  = $urandom_range(0, 8);
		count = $urandom_range(0, 10);
		hdr   = ($urandom_range(3) == 0) ? 32'($urandom) : (32'(plen) ^ key_reg);
		sum   = '0;
		for (int k = 0; k < count; k++) begin
			body.push_back(8'($urandom));
			sum = sum + 32'(body[k]) * 32'(k) + 32'(k);
		end
		sum = sum ^ mask_reg;
		if ($urandom_range(4) == 0)
			sum = sum ^ (32'd1 << $urandom_range(31));
		if ($urandom_range(9) < 7)
			msg.push_back(xrc_item_t'({CMD_BEGIN, 24'($urandom), 8'($urandom), 1'($urandom)}));
		for (int k = 0; k < 4; k++)
			msg.push_back(xrc_item_t'({CMD_DATA, 24'($urandom), hdr[31 - 8*k -: 8], 1'b0}));
		for (int k = 0; k < 4; k++)
			msg.push_back(xrc_item_t'({CMD_DATA, 24'($urandom), sum[8*k +: 8], 1'b0}));
		for (int k = 0; k < count; k++)
			msg.push_back(xrc_item_t'({CMD_DATA, 24'($urandom), body[k], 1'b0}));
		cut       = msg.size();
		mark_last = 1'b1;
		if ($urandom_range(9) == 0) begin
			cut       = $urandom_range(1, msg.size());
			mark_last = 1'($urandom);
		end
		for (int k = 0; k < cut; k++) begin
			it = msg[k];
			if (k == cut - 1 && mark_last)
				it.last = 1'b1;
			send_item(it, EXP_PREDICT, '0);
		end
	endtask

	// receiver stalls at random per cycle
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= dst_idle_pct);

	// ---------------------------------------------------------------- checking

	// every accepted result is scored against the oldest expectation
	always @(posedge clk) begin : check_results
		xrc_result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("[%0t] unexpected result: byte=%02h kind=%0d ok=%0b eor=%0b",
						$realtime, result.out_byte, result.kind, result.check_ok,
						result.end_of_run);
			end else begin
				want = expected_results.pop_front();
				if (want.kind == KIND_VERDICT) begin
					if (want.check_ok)
						verdicts_ok++;
					else
						verdicts_bad++;
				end
				if (result.out_byte !== want.out_byte || result.kind !== want.kind ||
						result.check_ok !== want.check_ok ||
						result.end_of_run !== want.end_of_run) begin
					errors++;
					if (errors <= MAX_SHOWN) begin
						$display("[%0t] result mismatch: exp byte=%02h kind=%0d ok=%0b eor=%0b",
							$realtime, want.out_byte, want.kind, want.check_ok,
							want.end_of_run);
						$display("    got byte=%02h kind=%0d ok=%0b eor=%0b",
							result.out_byte, result.kind, result.check_ok,
							result.end_of_run);
					end
				end
			end
		end
	end

	// watchdog: any transaction, register write or reset restarts the count
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (item_valid && item_ready) ||
				(result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: %0d idle cycles, %0d results outstanding",
				quiet_cycles, expected_results.size());
			$display("FAIL xor_ramp_cipher_with_checksum_unit");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		logic [31:0] phase_keys  [NUM_PHASES];
		logic [31:0] phase_masks [NUM_PHASES];
		logic        phase_dirs  [NUM_PHASES];
		int start;

		// register settings of the random part; extremes in phases 0, 1 and 4, zero mask in 5
		phase_keys  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom), 32'($urandom),
			32'hFFFF_FFFF, 32'($urandom)};
		phase_masks = '{32'hFFFF_FFFF, 32'h0000_0000, 32'($urandom), 32'($urandom),
			32'hFFFF_FFFF, 32'h0000_0000};
		phase_dirs  = '{DIR_ENCRYPT, DIR_DECRYPT, DIR_ENCRYPT, DIR_DECRYPT,
			DIR_DECRYPT, DIR_ENCRYPT};

		// directed table; typed expectations only where obvious from the inputs
		// encrypt, zero key: header is the plain big-endian length
		directed_rows.push_back(cfg_row(REG_KEY_BYTES, 32'h0000_0000));
		directed_rows.push_back(cfg_row(REG_CHECKSUM_MASK, 32'h0000_0000));
		directed_rows.push_back(cfg_row(REG_DIRECTION, 32'(DIR_ENCRYPT)));
		directed_rows.push_back(item_row(CMD_BEGIN, 24'h000000, 8'h00, 1'b0, EXP_HEADER, 32'h0000_0000));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h00, 1'b1, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_BEGIN, 24'hFFFFFF, 8'hFF, 1'b1, EXP_HEADER, 32'h00FF_FFFF));
		directed_rows.push_back(item_row(CMD_DATA,  24'hFFFFFF, 8'hFF, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'hA5, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h5A5A5A, 8'h5A, 1'b1, EXP_PREDICT, '0));
		// after end of message further data bytes reuse the kept header
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h3C, 1'b1, EXP_PREDICT, '0));
		// all-ones key and mask: header is the inverted length
		directed_rows.push_back(cfg_row(REG_KEY_BYTES, 32'hFFFF_FFFF));
		directed_rows.push_back(cfg_row(REG_CHECKSUM_MASK, 32'hFFFF_FFFF));
		directed_rows.push_back(item_row(CMD_BEGIN, 24'h000003, 8'h00, 1'b0, EXP_HEADER, 32'hFFFF_FFFC));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h00, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h81, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h7E, 1'b1, EXP_PREDICT, '0));
		// decrypt: begin gives nothing; last inside the header fails the verdict
		directed_rows.push_back(cfg_row(REG_DIRECTION, 32'(DIR_DECRYPT)));
		directed_rows.push_back(cfg_row(REG_KEY_BYTES, 32'h0000_0000));
		directed_rows.push_back(cfg_row(REG_CHECKSUM_MASK, 32'h0000_0000));
		directed_rows.push_back(item_row(CMD_BEGIN, 24'hFFFFFF, 8'hFF, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h12, 1'b1, EXP_VERDICT, 32'd0));
		// well-formed decrypt: length 1, sum 0x9A, one decoded byte and one
		// past the length that passes through
		directed_rows.push_back(item_row(CMD_BEGIN, 24'h000000, 8'h00, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h00, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h00, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h00, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h01, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h9A, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h00, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h00, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h00, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h40, 1'b0, EXP_PREDICT, '0));
		directed_rows.push_back(item_row(CMD_DATA,  24'h000000, 8'h99, 1'b1, EXP_PREDICT, '0));

		// single reset at the start
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].op == ROW_CFG) begin
				drain();
				write_reg(directed_rows[r].reg_index, directed_rows[r].word);
				cfg_wr_en <= 1'b0;
			end else begin
				send_item(directed_rows[r].it, directed_rows[r].form, directed_rows[r].word);
			end
		end

		// random part: two settings per idle profile (sender/receiver idle
		// 31/52, then 52/31, then none). Messages may be left open across a
		// settings change, so direction flips mid-message too.
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			src_idle_pct = (p < 2) ? 31 : (p < 4) ? 52 : 0;
			dst_idle_pct = (p < 2) ? 52 : (p < 4) ? 31 : 0;
			write_reg(REG_KEY_BYTES, phase_keys[p]);
			write_reg(REG_CHECKSUM_MASK, phase_masks[p]);
			write_reg(REG_DIRECTION, 32'(phase_dirs[p]));
			cfg_wr_en <= 1'b0;
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				// now and then the sender holds until the unit has emptied
				if ($urandom_range(19) == 0)
					drain();
				if (dir_reg == DIR_ENCRYPT)
					send_encrypt_message();
				else
					send_decrypt_message();
			end
		end

		drain();
		$display("covered %0d transactions in, %0d results out, verdicts %0d pass / %0d fail",
			items_sent, results_seen, verdicts_ok, verdicts_bad);
		$display("over %0d register settings and three idle profiles; %0d mismatches",
			NUM_PHASES + 3, errors);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS xor_ramp_cipher_with_checksum_unit");
		else
			$display("FAIL xor_ramp_cipher_with_checksum_unit");
		$finish;
	end

endmodule
